FILE: rtl/core/chacha_pkg.sv
// Shared types and constants for the ChaCha20 stream cipher block.
// Depends on nothing; the other files in rtl/core, except chacha_ram, refer to it by scoped names.
package chacha_pkg;

  // Register file geometry: seven registers, 64-bit data, 8-byte stride.
  localparam int APB_ADDR_W = 6;
  localparam int APB_DATA_W = 64;
  localparam int REG_IDX_LSB = 3;
  localparam int REG_IDX_W = 3;

  // Register indexes on the configuration port.
  localparam logic [REG_IDX_W-1:0] REG_KEY_PART_0 = 3'd0;
  localparam logic [REG_IDX_W-1:0] REG_KEY_PART_1 = 3'd1;
  localparam logic [REG_IDX_W-1:0] REG_KEY_PART_2 = 3'd2;
  localparam logic [REG_IDX_W-1:0] REG_KEY_PART_3 = 3'd3;
  localparam logic [REG_IDX_W-1:0] REG_NONCE_LOW = 3'd4;
  localparam logic [REG_IDX_W-1:0] REG_NONCE_HIGH = 3'd5;
  localparam logic [REG_IDX_W-1:0] REG_INIT_CTR = 3'd6;

  // The four "expand 32-byte k" constant words.
  localparam logic [31:0] SIGMA_0 = 32'h6170_7865;
  localparam logic [31:0] SIGMA_1 = 32'h3320_646e;
  localparam logic [31:0] SIGMA_2 = 32'h7962_2d32;
  localparam logic [31:0] SIGMA_3 = 32'h6b20_6574;

  // Keystream block geometry.
  localparam int WORDS = 16;
  localparam int WORD_IDX_W = 4;
  localparam int BYTE_POS_W = 6;
  localparam logic [BYTE_POS_W-1:0] LAST_BYTE_POS = 6'd63;

  // Configuration seen by the datapath.
  typedef struct packed {
    logic [7:0][31:0] key;
    logic [2:0][31:0] nonce;
    logic [31:0]      init_ctr;
  } cfg_t;

  // Sequencer states, one-hot.
  typedef enum logic [5:0] {
    S_IDLE   = 6'b000001,
    S_LOAD   = 6'b000010,
    S_ROUND  = 6'b000100,
    S_FEED   = 6'b001000,
    S_READ   = 6'b010000,
    S_RESULT = 6'b100000
  } state_t;

  // 32-bit rotate left by a constant or selected amount.
  function automatic logic [31:0] rotl32(input logic [31:0] v, input logic [4:0] s);
    logic [63:0] dbl;
    dbl = {v, v} << s;
    return dbl[63:32];
  endfunction

endpackage

FILE: rtl/core/chacha_ram.sv
// Generic single-write, single-read RAM with a registered read port.
// Depends on nothing; used for the keystream buffer.
module chacha_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

FILE: rtl/core/chacha_qr_unit.sv
// Half of a ChaCha quarter round: two add/xor/rotate steps on four words.
// Depends on chacha_pkg for the rotate function.
module chacha_qr_unit (
  input  logic        late,
  input  logic [31:0] a,
  input  logic [31:0] b,
  input  logic [31:0] c,
  input  logic [31:0] d,
  output logic [31:0] a_o,
  output logic [31:0] b_o,
  output logic [31:0] c_o,
  output logic [31:0] d_o
);

  logic [4:0] rot_d;
  logic [4:0] rot_b;

  // The first half rotates by 16 and 12, the second half by 8 and 7.
  assign rot_d = late ? 5'd8 : 5'd16;
  assign rot_b = late ? 5'd7 : 5'd12;

  // a += b; d ^= a; d <<<= r; c += d; b ^= c; b <<<= r.
  assign a_o = a + b;
  assign d_o = chacha_pkg::rotl32(d ^ a_o, rot_d);
  assign c_o = c + d_o;
  assign b_o = chacha_pkg::rotl32(b ^ c_o, rot_b);

endmodule

FILE: rtl/core/chacha_regs.sv
// APB-style configuration registers for key, nonce and initial counter.
// Depends on chacha_pkg for register indexes, widths and the cfg_t struct.
module chacha_regs (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [chacha_pkg::APB_ADDR_W-1:0] paddr,
  input  logic [chacha_pkg::APB_DATA_W-1:0] pwdata,
  output logic [chacha_pkg::APB_DATA_W-1:0] prdata,
  output logic                              pready,
  output chacha_pkg::cfg_t                  cfg,
  output logic                              ctr_load
);

  logic                                wr_en;
  logic [chacha_pkg::REG_IDX_W-1:0]    reg_idx;

  assign pready  = 1'b1;
  assign wr_en   = psel & penable & pwrite;
  assign reg_idx = paddr[chacha_pkg::REG_IDX_LSB +: chacha_pkg::REG_IDX_W];

  // The counter register also reloads the running block counter.
  assign ctr_load = wr_en && (reg_idx == chacha_pkg::REG_INIT_CTR);

  // Register writes; unknown indexes are dropped.
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= '0;
    end else if (wr_en) begin
      case (reg_idx)
        chacha_pkg::REG_KEY_PART_0: begin
          cfg.key[0] <= pwdata[31:0];
          cfg.key[1] <= pwdata[63:32];
        end
        chacha_pkg::REG_KEY_PART_1: begin
          cfg.key[2] <= pwdata[31:0];
          cfg.key[3] <= pwdata[63:32];
        end
        chacha_pkg::REG_KEY_PART_2: begin
          cfg.key[4] <= pwdata[31:0];
          cfg.key[5] <= pwdata[63:32];
        end
        chacha_pkg::REG_KEY_PART_3: begin
          cfg.key[6] <= pwdata[31:0];
          cfg.key[7] <= pwdata[63:32];
        end
        chacha_pkg::REG_NONCE_LOW: begin
          cfg.nonce[0] <= pwdata[31:0];
          cfg.nonce[1] <= pwdata[63:32];
        end
        chacha_pkg::REG_NONCE_HIGH: begin
          cfg.nonce[2] <= pwdata[31:0];
        end
        chacha_pkg::REG_INIT_CTR: begin
          cfg.init_ctr <= pwdata[31:0];
        end
        default: begin
        end
      endcase
    end
  end

  // Read-back mux.
  always_comb begin
    case (reg_idx)
      chacha_pkg::REG_KEY_PART_0: prdata = {cfg.key[1], cfg.key[0]};
      chacha_pkg::REG_KEY_PART_1: prdata = {cfg.key[3], cfg.key[2]};
      chacha_pkg::REG_KEY_PART_2: prdata = {cfg.key[5], cfg.key[4]};
      chacha_pkg::REG_KEY_PART_3: prdata = {cfg.key[7], cfg.key[6]};
      chacha_pkg::REG_NONCE_LOW:  prdata = {cfg.nonce[1], cfg.nonce[0]};
      chacha_pkg::REG_NONCE_HIGH: prdata = {32'd0, cfg.nonce[2]};
      chacha_pkg::REG_INIT_CTR:   prdata = {32'd0, cfg.init_ctr};
      default:                    prdata = '0;
    endcase
  end

endmodule

FILE: rtl/core/chacha20_stream_cipher.sv
// Top level of the ChaCha20 stream cipher: sequencer, working state and keystream buffer.
// Depends on chacha_pkg, chacha_regs, chacha_qr_unit and chacha_ram.

// XORs one message byte per beat with the ChaCha20 keystream; encryption and
// decryption are the same. The block takes one byte at a time and is not ready
// again until its result is in the output register. A byte whose keystream
// block is already buffered passes through accept, buffer read and result. The
// first byte of each 64-byte block also pays for generating the block: a load
// step, DOUBLE_ROUNDS double rounds on the shared half-quarter-round unit and
// feed-forward adds that also fill the buffer. A byte with last_byte set ends
// the message: the next byte starts a fresh block from initial_counter.
// Registers on the 64-bit APB-style port sit at 8-byte steps: key parts 0 to
// 3, nonce low, nonce high, initial counter. Writing the initial counter also
// reloads the running block counter. Write registers only while the block is
// idle.
module chacha20_stream_cipher #(
  parameter int DOUBLE_ROUNDS = 10
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [chacha_pkg::APB_ADDR_W-1:0] paddr,
  input  logic [chacha_pkg::APB_DATA_W-1:0] pwdata,
  output logic [chacha_pkg::APB_DATA_W-1:0] prdata,
  output logic                              pready,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic [7:0]                        data_byte,
  input  logic                              last_byte,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic [7:0]                        out_byte,
  output logic                              out_last
);

  localparam int DR_W = $clog2(DOUBLE_ROUNDS);

  chacha_pkg::cfg_t  cfg;
  logic              ctr_load;

  chacha_pkg::state_t state;
  chacha_pkg::state_t state_next;

  logic [31:0] st [chacha_pkg::WORDS];
  logic [31:0] st_next [chacha_pkg::WORDS];
  logic [31:0] start_w [chacha_pkg::WORDS];

  logic [3:0]                         step;
  logic [DR_W-1:0]                    dr_cnt;
  logic [chacha_pkg::WORD_IDX_W-1:0]  ff_idx;
  logic [chacha_pkg::BYTE_POS_W-1:0]  byte_position;
  logic [31:0]                        block_counter;
  logic                               buffer_valid;
  logic [7:0]                         data_hold;
  logic                               last_hold;

  logic [31:0] qa_o;
  logic [31:0] qb_o;
  logic [31:0] qc_o;
  logic [31:0] qd_o;
  logic [31:0] qb_in;
  logic [31:0] ram_rdata;
  logic [7:0]  ks_byte;
  logic        round_end;
  logic        result_take;

  // Configuration registers.
  chacha_regs u_regs (
    .clk      (clk),
    .rst      (rst),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready),
    .cfg      (cfg),
    .ctr_load (ctr_load)
  );

  // Start words: constants, key, block counter, nonce.
  always_comb begin
    start_w[0]  = chacha_pkg::SIGMA_0;
    start_w[1]  = chacha_pkg::SIGMA_1;
    start_w[2]  = chacha_pkg::SIGMA_2;
    start_w[3]  = chacha_pkg::SIGMA_3;
    start_w[4]  = cfg.key[0];
    start_w[5]  = cfg.key[1];
    start_w[6]  = cfg.key[2];
    start_w[7]  = cfg.key[3];
    start_w[8]  = cfg.key[4];
    start_w[9]  = cfg.key[5];
    start_w[10] = cfg.key[6];
    start_w[11] = cfg.key[7];
    start_w[12] = block_counter;
    start_w[13] = cfg.nonce[0];
    start_w[14] = cfg.nonce[1];
    start_w[15] = cfg.nonce[2];
  end

  // The shared unit always works on column 0; during feed-forward its first
  // adder sums the front word of the state with the matching start word.
  assign qb_in = (state == chacha_pkg::S_FEED) ? start_w[ff_idx] : st[4];

  chacha_qr_unit u_qr (
    .late (step[0]),
    .a    (st[0]),
    .b    (qb_in),
    .c    (st[8]),
    .d    (st[12]),
    .a_o  (qa_o),
    .b_o  (qb_o),
    .c_o  (qc_o),
    .d_o  (qd_o)
  );

  // Working state update. After each full quarter round every row rotates
  // left by one so the next column lands in column 0. After the fourth
  // column round the rows are skewed so the diagonals become columns, and
  // after the fourth diagonal round the skew is undone.
  always_comb begin
    logic [31:0] sh [chacha_pkg::WORDS];
    logic [31:0] qo [4];
    for (int k = 0; k < chacha_pkg::WORDS; k++) begin
      st_next[k] = st[k];
      sh[k] = st[k];
    end
    qo[0] = qa_o;
    qo[1] = qb_o;
    qo[2] = qc_o;
    qo[3] = qd_o;
    for (int r = 0; r < 4; r++) begin
      for (int c = 0; c < 3; c++) begin
        sh[r * 4 + c] = st[r * 4 + c + 1];
      end
      sh[r * 4 + 3] = qo[r];
    end
    case (state)
      chacha_pkg::S_LOAD: begin
        for (int k = 0; k < chacha_pkg::WORDS; k++) begin
          st_next[k] = start_w[k];
        end
      end
      chacha_pkg::S_ROUND: begin
        if (!step[0]) begin
          for (int r = 0; r < 4; r++) begin
            st_next[r * 4] = qo[r];
          end
        end else if (step[3:1] == 3'd3) begin
          for (int r = 0; r < 4; r++) begin
            for (int c = 0; c < 4; c++) begin
              st_next[r * 4 + c] = sh[r * 4 + ((c + r) % 4)];
            end
          end
        end else if (step[3:1] == 3'd7) begin
          for (int r = 0; r < 4; r++) begin
            for (int c = 0; c < 4; c++) begin
              st_next[r * 4 + c] = sh[r * 4 + ((c + 4 - r) % 4)];
            end
          end
        end else begin
          for (int k = 0; k < chacha_pkg::WORDS; k++) begin
            st_next[k] = sh[k];
          end
        end
      end
      chacha_pkg::S_FEED: begin
        for (int k = 0; k < chacha_pkg::WORDS - 1; k++) begin
          st_next[k] = st[k + 1];
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    st <= st_next;
  end

  // Keystream buffer: one 32-bit word per state word, filled during feed-forward.
  chacha_ram #(
    .WIDTH (32),
    .DEPTH (chacha_pkg::WORDS)
  ) u_ks_ram (
    .clk   (clk),
    .we    (state == chacha_pkg::S_FEED),
    .waddr (ff_idx),
    .wdata (qa_o),
    .raddr (byte_position[chacha_pkg::BYTE_POS_W-1:2]),
    .rdata (ram_rdata)
  );

  // Little-endian byte pick from the buffered word.
  always_comb begin
    case (byte_position[1:0])
      2'd0:    ks_byte = ram_rdata[7:0];
      2'd1:    ks_byte = ram_rdata[15:8];
      2'd2:    ks_byte = ram_rdata[23:16];
      default: ks_byte = ram_rdata[31:24];
    endcase
  end

  assign in_ready    = (state == chacha_pkg::S_IDLE);
  assign round_end   = (step == 4'd15) && (dr_cnt == DR_W'(DOUBLE_ROUNDS - 1));
  assign result_take = (state == chacha_pkg::S_RESULT) && (!out_valid || out_ready);

  // Sequencer.
  always_comb begin
    state_next = state;
    case (state)
      chacha_pkg::S_IDLE: begin
        if (in_valid) begin
          state_next = buffer_valid ? chacha_pkg::S_READ : chacha_pkg::S_LOAD;
        end
      end
      chacha_pkg::S_LOAD: begin
        state_next = chacha_pkg::S_ROUND;
      end
      chacha_pkg::S_ROUND: begin
        if (round_end) begin
          state_next = chacha_pkg::S_FEED;
        end
      end
      chacha_pkg::S_FEED: begin
        if (ff_idx == 4'd15) begin
          state_next = chacha_pkg::S_READ;
        end
      end
      chacha_pkg::S_READ: begin
        state_next = chacha_pkg::S_RESULT;
      end
      chacha_pkg::S_RESULT: begin
        if (result_take) begin
          state_next = chacha_pkg::S_IDLE;
        end
      end
      default: begin
        state_next = chacha_pkg::S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= chacha_pkg::S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Round and feed-forward counters.
  always_ff @(posedge clk) begin
    if (rst) begin
      step   <= '0;
      dr_cnt <= '0;
      ff_idx <= '0;
    end else begin
      case (state)
        chacha_pkg::S_LOAD: begin
          step   <= '0;
          dr_cnt <= '0;
          ff_idx <= '0;
        end
        chacha_pkg::S_ROUND: begin
          step <= step + 4'd1;
          if (step == 4'd15) begin
            dr_cnt <= dr_cnt + DR_W'(1);
          end
        end
        chacha_pkg::S_FEED: begin
          ff_idx <= ff_idx + 4'd1;
        end
        default: begin
        end
      endcase
    end
  end

  // Input beat capture.
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      data_hold <= data_byte;
      last_hold <= last_byte;
    end
  end

  // Stream position, buffer state and block counter.
  always_ff @(posedge clk) begin
    if (rst) begin
      byte_position <= '0;
      block_counter <= '0;
      buffer_valid  <= 1'b0;
    end else if (state == chacha_pkg::S_FEED && ff_idx == 4'd15) begin
      buffer_valid <= 1'b1;
    end else if (result_take) begin
      if (last_hold) begin
        byte_position <= '0;
        buffer_valid  <= 1'b0;
        block_counter <= cfg.init_ctr;
      end else begin
        byte_position <= byte_position + 6'd1;
        if (byte_position == chacha_pkg::LAST_BYTE_POS) begin
          buffer_valid  <= 1'b0;
          block_counter <= block_counter + 32'd1;
        end
      end
    end else if (ctr_load) begin
      block_counter <= pwdata[31:0];
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (result_take) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (result_take) begin
      out_byte <= data_hold ^ ks_byte;
      out_last <= last_hold;
    end
  end

endmodule

FILE: dv/tb_chacha20_stream_cipher.sv
// Self-checking testbench for chacha20_stream_cipher: byte stream in, XORed byte stream out.
// Depends on chacha_pkg and the RTL under rtl/core; a built-in keystream predictor checks
// every output beat.

module tb_chacha20_stream_cipher;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int N_DOUBLE_ROUNDS = 10;
  // Worst case for one byte: block generation plus the buffer read and result cycles.
  localparam int BLOCK_LATENCY = 16 * N_DOUBLE_ROUNDS + 20;
  localparam int LONG_HOLD_CYCLES = 500;
  localparam logic [chacha_pkg::REG_IDX_W-1:0] REG_UNMAPPED = 3'd7;
  localparam logic [chacha_pkg::REG_IDX_W-1:0] ALL_REGS [7] = '{
    chacha_pkg::REG_KEY_PART_0, chacha_pkg::REG_KEY_PART_1,
    chacha_pkg::REG_KEY_PART_2, chacha_pkg::REG_KEY_PART_3,
    chacha_pkg::REG_NONCE_LOW, chacha_pkg::REG_NONCE_HIGH, chacha_pkg::REG_INIT_CTR};
  // The "expand 32-byte k" words, listed from element 3 down to element 0.
  localparam logic [3:0][31:0] EXPAND_WORDS = {32'h6b20_6574, 32'h7962_2d32,
                                               32'h3320_646e, 32'h6170_7865};

  typedef struct packed {
    logic [7:0] cipher_byte;
    logic       is_last;
  } cipher_beat_t;

  logic                              clk;
  logic                              rst;
  logic                              psel;
  logic                              penable;
  logic                              pwrite;
  logic [chacha_pkg::APB_ADDR_W-1:0] paddr;
  logic [chacha_pkg::APB_DATA_W-1:0] pwdata;
  logic [chacha_pkg::APB_DATA_W-1:0] prdata;
  logic                              pready;
  logic                              in_valid;
  logic                              in_ready;
  logic [7:0]                        data_byte;
  logic                              last_byte;
  logic                              out_valid;
  logic                              out_ready;
  logic [7:0]                        out_byte;
  logic                              out_last;

  // Register mirror and keystream predictor state.
  logic [63:0] key_half [4];
  logic [63:0] nonce_lo;
  logic [31:0] nonce_hi;
  logic [31:0] ctr_start;
  logic [31:0] ctr_running;
  logic [7:0]  stream_bytes [64];
  logic [5:0]  stream_pos;
  logic        stream_loaded;
  logic [31:0] mix_words [16];

  cipher_beat_t expected_beats [$];
  cipher_beat_t want;
  int err_count;
  int send_idle_pct;
  int recv_stall_pct;
  bit long_hold_req;
  int hold_left;

  chacha20_stream_cipher #(
    .DOUBLE_ROUNDS(N_DOUBLE_ROUNDS)
  ) dut (
    .clk(clk),
    .rst(rst),
    .psel(psel),
    .penable(penable),
    .pwrite(pwrite),
    .paddr(paddr),
    .pwdata(pwdata),
    .prdata(prdata),
    .pready(pready),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .data_byte(data_byte),
    .last_byte(last_byte),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_byte(out_byte),
    .out_last(out_last)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // ---------------------------------------------------------------- predictor

  function automatic logic [31:0] rol32(input logic [31:0] v, input int s);
    return (v << s) | (v >> (32 - s));
  endfunction

  function automatic void mix_quarter(input int a, input int b, input int c, input int d);
    mix_words[a] = mix_words[a] + mix_words[b];
    mix_words[d] = rol32(mix_words[d] ^ mix_words[a], 16);
    mix_words[c] = mix_words[c] + mix_words[d];
    mix_words[b] = rol32(mix_words[b] ^ mix_words[c], 12);
    mix_words[a] = mix_words[a] + mix_words[b];
    mix_words[d] = rol32(mix_words[d] ^ mix_words[a], 8);
    mix_words[c] = mix_words[c] + mix_words[d];
    mix_words[b] = rol32(mix_words[b] ^ mix_words[c], 7);
  endfunction

  // Builds the next 64-byte keystream block from the mirrored key, nonce and counter.
  function automatic void refill_keystream();
    logic [31:0] init_w [16];
    logic [31:0] sum;
    for (int i = 0; i < 4; i++) begin
      init_w[i] = EXPAND_WORDS[i];
      init_w[4 + 2 * i] = key_half[i][31:0];
      init_w[5 + 2 * i] = key_half[i][63:32];
    end
    init_w[12] = ctr_running;
    init_w[13] = nonce_lo[31:0];
    init_w[14] = nonce_lo[63:32];
    init_w[15] = nonce_hi;
    mix_words = init_w;
    for (int r = 0; r < N_DOUBLE_ROUNDS; r++) begin
      mix_quarter(0, 4, 8, 12);
      mix_quarter(1, 5, 9, 13);
      mix_quarter(2, 6, 10, 14);
      mix_quarter(3, 7, 11, 15);
      mix_quarter(0, 5, 10, 15);
      mix_quarter(1, 6, 11, 12);
      mix_quarter(2, 7, 8, 13);
      mix_quarter(3, 4, 9, 14);
    end
    for (int i = 0; i < 16; i++) begin
      sum = mix_words[i] + init_w[i];
      for (int k = 0; k < 4; k++) stream_bytes[4 * i + k] = sum[8 * k +: 8];
    end
  endfunction

  // Works out the output beat for one accepted input byte and advances the stream.
  function automatic void predict_cipher_byte(input logic [7:0] d, input logic l);
    cipher_beat_t beat;
    if (!stream_loaded) begin
      refill_keystream();
      stream_loaded = 1'b1;
    end
    beat.cipher_byte = d ^ stream_bytes[stream_pos];
    beat.is_last = l;
    expected_beats.insert(expected_beats.size(), beat);
    if (l) begin
      stream_pos = '0;
      stream_loaded = 1'b0;
      ctr_running = ctr_start;
    end else begin
      stream_pos = stream_pos + 6'd1;
      if (stream_pos == '0) begin
        stream_loaded = 1'b0;
        ctr_running = ctr_running + 32'd1;
      end
    end
  endfunction

  function automatic void apply_config(input logic [chacha_pkg::REG_IDX_W-1:0] idx,
                                       input logic [63:0] v);
    case (idx)
      chacha_pkg::REG_KEY_PART_0: key_half[0] = v;
      chacha_pkg::REG_KEY_PART_1: key_half[1] = v;
      chacha_pkg::REG_KEY_PART_2: key_half[2] = v;
      chacha_pkg::REG_KEY_PART_3: key_half[3] = v;
      chacha_pkg::REG_NONCE_LOW:  nonce_lo = v;
      chacha_pkg::REG_NONCE_HIGH: nonce_hi = v[31:0];
      chacha_pkg::REG_INIT_CTR: begin
        ctr_start = v[31:0];
        ctr_running = v[31:0];
      end
      default: ;
    endcase
  endfunction

  function automatic logic [63:0] mirror_value(input logic [chacha_pkg::REG_IDX_W-1:0] idx);
    case (idx)
      chacha_pkg::REG_KEY_PART_0: return key_half[0];
      chacha_pkg::REG_KEY_PART_1: return key_half[1];
      chacha_pkg::REG_KEY_PART_2: return key_half[2];
      chacha_pkg::REG_KEY_PART_3: return key_half[3];
      chacha_pkg::REG_NONCE_LOW:  return nonce_lo;
      chacha_pkg::REG_NONCE_HIGH: return {32'd0, nonce_hi};
      chacha_pkg::REG_INIT_CTR:   return {32'd0, ctr_start};
      default:                    return '0;
    endcase
  endfunction

  // ---------------------------------------------------------------- monitor

  // Predict on every accepted input beat, then check every accepted output beat.
  always @(posedge clk) begin
    if (!rst) begin
      if (in_valid && in_ready) predict_cipher_byte(data_byte, last_byte);
      if (out_valid && out_ready) begin
        if (expected_beats.size() == 0) begin
          $display("%0t: unexpected output beat, expected none, actual byte %02h last %0b",
                   $time, out_byte, out_last);
          err_count++;
        end else begin
          want = expected_beats.pop_front();
          if (out_byte !== want.cipher_byte) begin
            $display("%0t: out_byte mismatch, expected %02h, actual %02h",
                     $time, want.cipher_byte, out_byte);
            err_count++;
          end
          if (out_last !== want.is_last) begin
            $display("%0t: out_last mismatch, expected %0b, actual %0b",
                     $time, want.is_last, out_last);
            err_count++;
          end
        end
      end
    end
  end

  // ---------------------------------------------------------------- receiver

  // Random stalls, plus one long hold-off on request to fill the block up.
  initial begin
    out_ready = 1'b0;
    forever begin
      @(negedge clk);
      if (long_hold_req) begin
        hold_left = LONG_HOLD_CYCLES;
        long_hold_req = 1'b0;
      end
      if (hold_left > 0) begin
        out_ready = 1'b0;
        hold_left--;
      end else begin
        out_ready = ($urandom_range(99) >= recv_stall_pct);
      end
    end
  end

  // ---------------------------------------------------------------- drivers

  // All driver tasks start and end at a falling edge.
  task automatic send_cipher_input(input logic [7:0] d, input logic l);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid = 1'b0;
      @(negedge clk);
    end
    in_valid = 1'b1;
    data_byte = d;
    last_byte = l;
    do @(posedge clk); while (!in_ready);
    @(negedge clk);
  endtask

  task automatic send_message(input int len, input bit terminate);
    for (int i = 0; i < len; i++) begin
      send_cipher_input(8'($urandom_range(255)), terminate && (i == len - 1));
    end
  endtask

  task automatic reg_write(input logic [chacha_pkg::REG_IDX_W-1:0] idx,
                           input logic [63:0] v);
    psel = 1'b1;
    penable = 1'b0;
    pwrite = 1'b1;
    paddr = '0;
    paddr[chacha_pkg::REG_IDX_LSB +: chacha_pkg::REG_IDX_W] = idx;
    pwdata = v;
    @(negedge clk);
    penable = 1'b1;
    do @(posedge clk); while (!pready);
    apply_config(idx, v);
    @(negedge clk);
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
  endtask

  task automatic check_register(input logic [chacha_pkg::REG_IDX_W-1:0] idx);
    logic [63:0] mask;
    logic [63:0] got;
    mask = (idx == chacha_pkg::REG_NONCE_HIGH || idx == chacha_pkg::REG_INIT_CTR) ?
           64'h0000_0000_ffff_ffff : '1;
    psel = 1'b1;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    paddr[chacha_pkg::REG_IDX_LSB +: chacha_pkg::REG_IDX_W] = idx;
    @(negedge clk);
    penable = 1'b1;
    do @(posedge clk); while (!pready);
    got = prdata & mask;
    if (got !== mirror_value(idx)) begin
      $display("%0t: register %0d readback mismatch, expected %016h, actual %016h",
               $time, idx, mirror_value(idx), got);
      err_count++;
    end
    @(negedge clk);
    psel = 1'b0;
    penable = 1'b0;
  endtask

  // Stop sending and let every expected beat come out before touching registers.
  task automatic settle();
    in_valid = 1'b0;
    while (expected_beats.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  function automatic logic [63:0] pick_value();
    case ($urandom_range(3))
      0:       return '0;
      1:       return '1;
      default: return {$urandom, $urandom};
    endcase
  endfunction

  function automatic int pick_message_len();
    int r;
    r = $urandom_range(9);
    if (r < 3) return $urandom_range(8, 1);
    if (r < 8) return $urandom_range(70, 9);
    return $urandom_range(200, 64);
  endfunction

  // ---------------------------------------------------------------- tests

  // Field extremes, single-byte messages, and register writes while a block
  // is still buffered: the old keystream must be used up first.
  task automatic test_directed_cases();
    send_idle_pct = 0;
    recv_stall_pct = 0;
    send_cipher_input(8'h00, 1'b1);
    send_cipher_input(8'hff, 1'b1);
    send_cipher_input(8'h00, 1'b0);
    send_cipher_input(8'hff, 1'b0);
    send_cipher_input(8'h55, 1'b0);
    send_cipher_input(8'haa, 1'b0);
    settle();
    reg_write(chacha_pkg::REG_KEY_PART_0, 64'h0706_0504_0302_0100);
    reg_write(chacha_pkg::REG_KEY_PART_1, 64'h0f0e_0d0c_0b0a_0908);
    reg_write(chacha_pkg::REG_KEY_PART_2, 64'h1716_1514_1312_1110);
    reg_write(chacha_pkg::REG_KEY_PART_3, 64'h1f1e_1d1c_1b1a_1918);
    reg_write(chacha_pkg::REG_NONCE_LOW, 64'h4a00_0000_0000_0000);
    reg_write(chacha_pkg::REG_NONCE_HIGH, 64'h0000_0000_0000_0000);
    send_cipher_input(8'h0f, 1'b0);
    send_cipher_input(8'hf0, 1'b1);
    send_cipher_input(8'h81, 1'b1);
    send_cipher_input(8'h7e, 1'b0);
    send_cipher_input(8'h01, 1'b0);
    send_cipher_input(8'h80, 1'b0);
    settle();
    // The counter reload only applies from the next block.
    reg_write(chacha_pkg::REG_INIT_CTR, 64'h0000_0000_ffff_ffff);
    send_cipher_input(8'h3c, 1'b0);
    send_cipher_input(8'hc3, 1'b1);
    send_cipher_input(8'h5a, 1'b1);
    settle();
    // A write to an index with no register behind it changes nothing.
    reg_write(REG_UNMAPPED, '1);
    send_cipher_input(8'ha5, 1'b0);
    send_cipher_input(8'h5a, 1'b1);
    settle();
  endtask

  task automatic test_register_readback();
    foreach (ALL_REGS[i]) reg_write(ALL_REGS[i], {$urandom, $urandom});
    reg_write(REG_UNMAPPED, {$urandom, $urandom});
    foreach (ALL_REGS[i]) check_register(ALL_REGS[i]);
  endtask

  // All-ones key and nonce, counter wrapping through zero over long messages.
  task automatic test_counter_wrap();
    send_idle_pct = 0;
    recv_stall_pct = 0;
    reg_write(chacha_pkg::REG_KEY_PART_0, '1);
    reg_write(chacha_pkg::REG_KEY_PART_1, '1);
    reg_write(chacha_pkg::REG_KEY_PART_2, '1);
    reg_write(chacha_pkg::REG_KEY_PART_3, '1);
    reg_write(chacha_pkg::REG_NONCE_LOW, '1);
    reg_write(chacha_pkg::REG_NONCE_HIGH, '1);
    reg_write(chacha_pkg::REG_INIT_CTR, 64'h0000_0000_ffff_ffff);
    send_message(150, 1'b1);
    send_message(70, 1'b1);
    settle();
  endtask

  // Random messages under one idling profile; some messages are left open so
  // that the next phase starts inside a buffered block.
  task automatic test_random_traffic(input int n_items, input int send_pct, input int recv_pct);
    int sent;
    int len;
    settle();
    foreach (ALL_REGS[i]) reg_write(ALL_REGS[i], pick_value());
    send_idle_pct = send_pct;
    recv_stall_pct = recv_pct;
    sent = 0;
    while (sent < n_items) begin
      len = pick_message_len();
      send_message(len, $urandom_range(9) != 0);
      sent += len;
    end
    settle();
  endtask

  // The receiver holds off for a long stretch while bytes keep coming.
  task automatic test_backpressure();
    send_idle_pct = 0;
    recv_stall_pct = 0;
    long_hold_req = 1'b1;
    send_message(24, 1'b1);
    settle();
  endtask

  // ---------------------------------------------------------------- sequence

  initial begin
    rst = 1'b1;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    in_valid = 1'b0;
    data_byte = '0;
    last_byte = 1'b0;
    err_count = 0;
    send_idle_pct = 0;
    recv_stall_pct = 0;
    long_hold_req = 1'b0;
    hold_left = 0;
    key_half = '{default: '0};
    nonce_lo = '0;
    nonce_hi = '0;
    ctr_start = '0;
    ctr_running = '0;
    stream_pos = '0;
    stream_loaded = 1'b0;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    test_directed_cases();
    test_register_readback();
    test_counter_wrap();
    test_random_traffic(350, 0, 0);
    test_random_traffic(350, 80, 0);
    test_random_traffic(350, 0, 80);
    test_random_traffic(350, 23, 23);
    test_backpressure();

    repeat (BLOCK_LATENCY) @(negedge clk);
    if (err_count == 0 && expected_beats.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

  // Watchdog, far beyond the slowest correct run.
  initial begin
    #20_000_000;
    $display("TEST FAILED");
    $finish;
  end

endmodule

FILE: chacha20_stream_cipher.f
rtl/core/chacha_pkg.sv
rtl/core/chacha_ram.sv
rtl/core/chacha_qr_unit.sv
rtl/core/chacha_regs.sv
rtl/core/chacha20_stream_cipher.sv
dv/tb_chacha20_stream_cipher.sv
